/* design/dth_pkg.sv */
// ----------------------------------------------------------------------------
// dth_pkg
// Shared types, codes and the window decision for the hysteresis block.
// ----------------------------------------------------------------------------
package dth_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAG_BITS_DEF  = 16;

  localparam int MAG_W  = 16;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 3;
  localparam int ROW_W  = 13;

  localparam logic [CIDX_W-1:0] CFG_LOW    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_HIGH   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_WIDTH  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_HEIGHT = 3'd3;

  typedef logic [1:0] level_t;
  localparam level_t LVL_NONE   = 2'd0;
  localparam level_t LVL_WEAK   = 2'd1;
  localparam level_t LVL_STRONG = 2'd2;

  // one window column: top [5:4], middle [3:2], bottom [1:0]
  typedef logic [5:0] vec_t;
  localparam vec_t VEC_NONE = {LVL_NONE, LVL_NONE, LVL_NONE};

  localparam logic [7:0] EDGE_ON  = 8'd255;
  localparam logic [7:0] EDGE_OFF = 8'd0;

  // column event handed from the front to the back
  typedef struct packed {
    level_t lvl;     // bottom level of the new column
    logic   kind0;   // shift a blank column first (row boundary)
    logic   emit;    // produce a result
    logic   eof;     // result is the frame's final pixel
    logic   last;    // result is the last one of its input item
    logic   wr;      // update the line store
    logic   top_ok;  // two rows above lie inside the image
    logic   mid_ok;  // one row above lies inside the image
  } evt_t;

  localparam int EVT_BITS = $bits(evt_t);

  function automatic logic [7:0] decide(input vec_t l, input vec_t m, input vec_t r);
    logic any;
    any = (l[5:4] == LVL_STRONG) || (l[3:2] == LVL_STRONG) || (l[1:0] == LVL_STRONG) ||
          (r[5:4] == LVL_STRONG) || (r[3:2] == LVL_STRONG) || (r[1:0] == LVL_STRONG) ||
          (m[5:4] == LVL_STRONG) || (m[1:0] == LVL_STRONG);
    if (m[3:2] == LVL_STRONG) begin
      return EDGE_ON;
    end else if (m[3:2] == LVL_WEAK && any) begin
      return EDGE_ON;
    end
    return EDGE_OFF;
  endfunction

endpackage

/* design/dth_ram.sv */
// ----------------------------------------------------------------------------
// dth_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dth_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/dth_queue.sv */
// ----------------------------------------------------------------------------
// dth_queue
// Short register FIFO between the front and the back.
// ----------------------------------------------------------------------------
module dth_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign not_full  = count != NW'(DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rptr];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

/* design/dth_front.sv */
// ----------------------------------------------------------------------------
// dth_front
// Configuration registers, raster counters and level classification.
// Turns pixel and drain transfers into column events for the back.
// ----------------------------------------------------------------------------
module dth_front
  import dth_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAG_BITS  = MAG_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CIDX_W-1:0]            cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic                         s_action,
  input  logic [MAG_W-1:0]             s_magnitude,
  input  logic                         q_ready,
  output logic                         q_push,
  output evt_t                         q_evt,
  output logic [$clog2(MAX_WIDTH)-1:0] q_col
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int MK = (MAG_BITS < MAG_W) ? MAG_BITS : MAG_W;
  localparam logic [MAG_W-1:0] MAG_MASK = MAG_W'((33'd1 << MK) - 33'd1);

  logic [15:0]      low_thr;
  logic [15:0]      high_thr;
  logic [11:0]      img_w;
  logic [12:0]      img_h;
  logic [WW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [ROW_W-1:0] row;
  logic [CW-1:0]    col;
  logic [CW-1:0]    fcnt;
  logic             pend;
  logic             done;
  logic             col_end;
  logic             fcnt_end;
  logic             is_last;
  logic             row_ge1;
  logic             row_ge2;
  logic             acc;
  logic [MAG_W-1:0] mag;
  level_t           lvl;

  always_comb begin
    if (img_w == '0) begin
      w_eff = WW'(1);
    end else if (32'(img_w) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(img_w);
    end
    h_eff = (img_h == '0) ? ROW_W'(1) : img_h;
  end

  assign done     = row == h_eff;
  assign col_end  = (WW'(col) + WW'(1)) == w_eff;
  assign fcnt_end = (WW'(fcnt) + WW'(1)) == w_eff;
  assign is_last  = (row == h_eff - ROW_W'(1)) && col_end;
  assign row_ge1  = row != '0;
  assign row_ge2  = |row[ROW_W-1:1];
  assign mag      = s_magnitude & MAG_MASK;
  assign cfg_ready = 1'b1;
  assign s_tready  = !pend && q_ready;
  assign acc       = s_tvalid && s_tready;

  always_comb begin
    if (mag < low_thr) begin
      lvl = LVL_NONE;
    end else if (mag >= high_thr) begin
      lvl = LVL_STRONG;
    end else begin
      lvl = LVL_WEAK;
    end
  end

  always_comb begin
    q_push       = 1'b0;
    q_col        = '0;
    q_evt.lvl    = LVL_NONE;
    q_evt.kind0  = 1'b1;
    q_evt.emit   = 1'b1;
    q_evt.eof    = 1'b0;
    q_evt.last   = 1'b1;
    q_evt.wr     = 1'b0;
    q_evt.top_ok = row_ge2;
    q_evt.mid_ok = 1'b1;
    if (pend) begin
      // column shift after the frame's final pixel; it carries a result
      // only when the frame has at least two rows
      q_push     = q_ready;
      q_evt.emit = row_ge2;
    end else if (acc && !s_action && !done) begin
      q_push       = 1'b1;
      q_col        = col;
      q_evt.lvl    = lvl;
      q_evt.kind0  = col == '0;
      q_evt.emit   = (col == '0) ? row_ge2 : row_ge1;
      q_evt.last   = !(is_last && row_ge1);
      q_evt.wr     = 1'b1;
      q_evt.mid_ok = row_ge1;
    end else if (acc && s_action && done) begin
      q_push      = 1'b1;
      q_evt.kind0 = fcnt_end;
      q_col       = fcnt_end ? '0 : fcnt + CW'(1);
      q_evt.eof   = fcnt_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_thr  <= 16'd0;
      high_thr <= 16'hFFFF;
      img_w    <= 12'd2048;
      img_h    <= 13'd1;
      row      <= '0;
      col      <= '0;
      fcnt     <= '0;
      pend     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOW:    low_thr  <= cfg_data;
        CFG_HIGH:   high_thr <= cfg_data;
        CFG_WIDTH:  img_w    <= cfg_data[11:0];
        CFG_HEIGHT: img_h    <= cfg_data[12:0];
        default: ;
      endcase
      if (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT) begin
        row  <= '0;
        col  <= '0;
        fcnt <= '0;
        pend <= 1'b0;
      end
    end else begin
      if (pend && q_ready) begin
        pend <= 1'b0;
      end
      if (acc && !s_action && !done) begin
        if (col_end) begin
          col <= '0;
          row <= row + ROW_W'(1);
        end else begin
          col <= col + CW'(1);
        end
        if (is_last) begin
          pend <= 1'b1;
        end
      end
      if (acc && s_action && done) begin
        if (fcnt_end) begin
          row  <= '0;
          col  <= '0;
          fcnt <= '0;
        end else begin
          fcnt <= fcnt + CW'(1);
        end
      end
    end
  end

endmodule

/* design/dth_back.sv */
// ----------------------------------------------------------------------------
// dth_back
// Line store, 3x3 window and decision, with the output register.
// ----------------------------------------------------------------------------
module dth_back
  import dth_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  evt_t                         q_evt,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_edge,
  output logic                         out_eof,
  output logic                         out_last
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic          a_valid;
  evt_t          a_evt;
  logic [CW-1:0] a_col;
  logic          proc;
  logic          advance;
  logic          ram_we;
  logic [3:0]    ram_wdata;
  logic [3:0]    ram_rdata;
  logic [3:0]    rd;
  logic          byp_hit;
  logic [3:0]    byp_data;
  vec_t          v;
  vec_t          wb;
  vec_t          wc;
  logic [7:0]    edge_val;

  assign proc    = a_valid && (!out_valid || out_ready);
  assign advance = !a_valid || proc;
  assign q_pop   = advance && q_valid;

  // word: [3:2] two rows up, [1:0] one row up
  assign rd        = byp_hit ? byp_data : ram_rdata;
  assign ram_we    = proc && a_evt.wr;
  assign ram_wdata = {rd[1:0], a_evt.lvl};

  dth_ram #(
    .WIDTH (4),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (a_col),
    .wdata (ram_wdata),
    .re    (q_pop),
    .raddr (q_col),
    .rdata (ram_rdata)
  );

  assign v = {a_evt.top_ok ? rd[3:2] : LVL_NONE,
              a_evt.mid_ok ? rd[1:0] : LVL_NONE,
              a_evt.lvl};
  assign edge_val = a_evt.kind0 ? decide(wb, wc, VEC_NONE) : decide(wb, wc, v);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_evt    <= q_evt;
      a_col    <= q_col;
      // forward a write that lands on the address being read
      byp_data <= ram_wdata;
    end
    if (proc && a_evt.emit) begin
      out_edge <= edge_val;
      out_eof  <= a_evt.eof;
      out_last <= a_evt.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      byp_hit   <= 1'b0;
      out_valid <= 1'b0;
      wb        <= VEC_NONE;
      wc        <= VEC_NONE;
    end else begin
      if (advance) begin
        a_valid <= q_valid;
      end
      if (q_pop) begin
        byp_hit <= ram_we && (a_col == q_col);
      end
      if (proc) begin
        if (a_evt.kind0) begin
          wb <= VEC_NONE;
        end else begin
          wb <= wc;
        end
        wc <= v;
      end
      if (proc && a_evt.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_eof |-> out_last)
    else $error("frame end result not marked last of its transfer");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !proc |=> a_valid && $stable(a_col))
    else $error("stalled event lost its column");

  a_eof_emit: assert property (@(posedge clk) disable iff (rst)
    proc && a_evt.eof |-> a_evt.emit && a_evt.kind0)
    else $error("frame end event without a result");

endmodule

/* design/double_threshold_hysteresis_core.sv */
// ----------------------------------------------------------------------------
// double_threshold_hysteresis_core
// Double-threshold edge classification with one 3x3 hysteresis pass.
//
//   channel  dir  handshake         payload
//   s_*      in   tvalid/tready     tuser action, tdata magnitude
//   m_*      out  tvalid/tready     tdata edge_value, tlast end_of_frame,
//                                   tuser last_of_step
//   cfg_*    in   cfg_valid/ready   cfg_index, cfg_data
//
// One transfer per clock in steady state while the queue has room; the frame's
// final pixel also holds off the next transfer, since it queues the column
// shift that carries its trailing result and lines up the drain. Results follow
// the input by one row plus one pixel and pass through the queue, the line
// store read and the output register. Reset clears counters, window and queue;
// the line store needs no clearing. A stall on m_* backs up through the queue.
// ----------------------------------------------------------------------------
module double_threshold_hysteresis_core
  import dth_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAG_BITS  = MAG_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [MAG_W-1:0]  s_tdata,   // [15:0] magnitude
  input  logic              s_tuser,   // [0] action
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [7:0] edge_value
  output logic              m_tlast,
  output logic              m_tuser,   // [0] last_of_step
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = EVT_BITS + CW;

  logic          f_push;
  evt_t          f_evt;
  logic [CW-1:0] f_col;
  logic          q_not_full;
  logic          q_not_empty;
  logic          q_pop;
  logic [QW-1:0] q_head;
  evt_t          b_evt;
  logic [CW-1:0] b_col;

  dth_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAG_BITS  (MAG_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_action    (s_tuser),
    .s_magnitude (s_tdata),
    .q_ready     (q_not_full),
    .q_push      (f_push),
    .q_evt       (f_evt),
    .q_col       (f_col)
  );

  dth_queue #(
    .WIDTH (QW),
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_evt, f_col}),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  assign b_evt = q_head[QW-1:CW];
  assign b_col = q_head[CW-1:0];

  dth_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_evt     (b_evt),
    .q_col     (b_col),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_edge  (m_tdata),
    .out_eof   (m_tlast),
    .out_last  (m_tuser)
  );

endmodule

/* sim/tb_double_threshold_hysteresis_core.sv */
// ----------------------------------------------------------------------------
// tb_double_threshold_hysteresis_core
// Self-checking bench for the double-threshold hysteresis core. A queue of
// pixel and flush transfers feeds a clocked driver, and a tracking model of
// the line store and frame counters predicts each edge decision. A clocked
// monitor checks every output transfer in order against that prediction.
// Random gaps on the input and random stalls on the output are applied until
// the run goes quiet near its end; one long output hold is applied once.
// ----------------------------------------------------------------------------
module tb_double_threshold_hysteresis_core;
  import dth_pkg::*;

  localparam int LINE_MAX   = 2048;
  localparam int CYCLE_CAP  = 3000000;
  localparam int SETTLE_CYC = 40;

  typedef struct {
    logic        act;
    logic [15:0] mag;
  } pixel_item_t;

  typedef struct {
    logic [7:0] edge_val;
    logic       eof;
    logic       last;
  } edge_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [MAG_W-1:0]  s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;
  logic              m_tlast;
  logic              m_tuser;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  double_threshold_hysteresis_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // tracking model state
  logic [15:0]  thr_low = 16'd0;
  logic [15:0]  thr_high = 16'd65535;
  logic [11:0]  geo_width = 12'd2048;
  logic [12:0]  geo_height = 13'd1;
  level_t       line_lvl [4][LINE_MAX];
  int           row_cnt = 0;
  int           col_cnt = 0;
  int           flush_cnt = 0;

  pixel_item_t  pending_pixels[$];
  edge_result_t expected_edges[$];
  int           errors = 0;
  int           cycles = 0;
  int           queued = 0;
  bit           quiet = 1'b0;
  bit           long_hold = 1'b0;

  function automatic int eff_width();
    if (geo_width == 0) return 1;
    if (geo_width > LINE_MAX) return LINE_MAX;
    return int'(geo_width);
  endfunction

  function automatic int eff_height();
    return (geo_height == 0) ? 1 : int'(geo_height);
  endfunction

  function automatic level_t level_at(int r, int c, int w, int h);
    if (r < 0 || c < 0 || r >= h || c >= w) return LVL_NONE;
    return line_lvl[r & 3][c];
  endfunction

  function automatic void add_edge(int p, int w, int h, bit last);
    edge_result_t e;
    level_t       ctr;
    bit           strong_nb;
    int           r;
    int           c;
    r = p / w;
    c = p % w;
    ctr = level_at(r, c, w, h);
    strong_nb = 1'b0;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if ((dr != 0 || dc != 0) && level_at(r + dr, c + dc, w, h) == LVL_STRONG)
          strong_nb = 1'b1;
    if (ctr == LVL_STRONG || (ctr == LVL_WEAK && strong_nb)) e.edge_val = EDGE_ON;
    else e.edge_val = EDGE_OFF;
    e.eof  = (p == w * h - 1);
    e.last = last;
    expected_edges.insert(expected_edges.size(), e);
  endfunction

  function automatic void apply_hysteresis(pixel_item_t it);
    int     w;
    int     h;
    int     total;
    int     n;
    bit     e1;
    bit     e2;
    level_t lvl;
    w = eff_width();
    h = eff_height();
    total = w * h;
    n = row_cnt * w + col_cnt;
    if (!it.act) begin
      if (flush_cnt != 0 || n >= total) return;
      if (it.mag < thr_low) lvl = LVL_NONE;
      else if (it.mag >= thr_high) lvl = LVL_STRONG;
      else lvl = LVL_WEAK;
      line_lvl[row_cnt & 3][col_cnt] = lvl;
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      e1 = (n >= w + 1);
      e2 = (n == total - 1 && n >= w);
      if (e1) add_edge(n - w - 1, w, h, !e2);
      if (e2) add_edge(n - w, w, h, 1'b1);
    end else begin
      if (n < total) return;
      add_edge(total - w + flush_cnt, w, h, 1'b1);
      flush_cnt++;
      if (flush_cnt >= w) begin
        row_cnt = 0;
        col_cnt = 0;
        flush_cnt = 0;
      end
    end
  endfunction

  // driver
  pixel_item_t cur_pixel;
  int          tx_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) apply_hysteresis(cur_pixel);
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
          tx_gap = $urandom_range(0, 11);
          s_tvalid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          cur_pixel = pending_pixels.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= cur_pixel.mag;
          s_tuser  <= cur_pixel.act;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long output hold, counted on its own while the driver keeps sending
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  bit holding = 1'b0;

  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
    end else if (long_hold && !hold_done) begin
      hold_cnt  = 400;
      hold_done = 1'b1;
    end
    holding <= hold_cnt > 0;
  end

  // monitor and output back-pressure
  int rx_gap = 0;

  always @(posedge clk) begin
    edge_result_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_edges.size() == 0) begin
          errors++;
          $display("%0t: unexpected result expected none actual edge=%0d eof=%0b last=%0b",
                   $time, m_tdata, m_tlast, m_tuser);
        end else begin
          e = expected_edges.pop_front();
          if (m_tdata !== e.edge_val) begin
            errors++;
            $display("%0t: edge_value expected %0d actual %0d", $time, e.edge_val, m_tdata);
          end
          if (m_tlast !== e.eof) begin
            errors++;
            $display("%0t: end_of_frame expected %0b actual %0b", $time, e.eof, m_tlast);
          end
          if (m_tuser !== e.last) begin
            errors++;
            $display("%0t: last_of_step expected %0b actual %0b", $time, e.last, m_tuser);
          end
        end
      end
      if (holding) begin
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 12) == 0) begin
        rx_gap = $urandom_range(0, 11);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_pixels.size() != 0 || s_tvalid || expected_edges.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LOW:  thr_low = val;
      CFG_HIGH: thr_high = val;
      default: begin
        if (idx == CFG_WIDTH) geo_width = val[11:0];
        else geo_height = val[12:0];
        row_cnt = 0;
        col_cnt = 0;
        flush_cnt = 0;
      end
    endcase
  endtask

  task automatic set_frame(int lo, int hi, int w, int h);
    wait_idle();
    cfg_write(CFG_LOW, lo[15:0]);
    cfg_write(CFG_HIGH, hi[15:0]);
    cfg_write(CFG_WIDTH, w[15:0]);
    cfg_write(CFG_HEIGHT, h[15:0]);
  endtask

  task automatic push_item(logic act, logic [15:0] mag);
    pixel_item_t it;
    it.act = act;
    it.mag = mag;
    pending_pixels.insert(pending_pixels.size(), it);
    queued++;
  endtask

  function automatic logic [15:0] pick_mag();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 65535));
      1: return thr_low - 16'($urandom_range(0, 2));
      2: return thr_high + 16'($urandom_range(0, 2)) - 16'd1;
      3: return 16'($urandom_range(0, 1) ? 65535 : 0);
      default: return 16'($urandom_range(thr_low < thr_high ? thr_low : 0,
                                         thr_low < thr_high ? thr_high : 65535));
    endcase
  endfunction

  // full frame of pixels then the drain; noise adds ignored transfers
  task automatic run_frame(bit noise);
    int w;
    int h;
    w = eff_width();
    h = eff_height();
    for (int i = 0; i < w * h; i++) begin
      if (noise && $urandom_range(0, 30) == 0) push_item(1'b1, 16'($urandom));
      push_item(1'b0, pick_mag());
    end
    for (int i = 0; i < w; i++) begin
      if (noise && $urandom_range(0, 20) == 0) push_item(1'b0, 16'($urandom));
      push_item(1'b1, 16'($urandom));
    end
  endtask

  initial begin
    int w;
    int h;
    int lo;
    int hi;
    int phase;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // two directed 3x3 frames around the thresholds, with out-of-order transfers
    set_frame(100, 1000, 3, 3);
    push_item(1'b1, 16'hFFFF);
    push_item(1'b0, 16'd0);     push_item(1'b0, 16'd99);   push_item(1'b0, 16'd100);
    push_item(1'b0, 16'd999);   push_item(1'b0, 16'd500);  push_item(1'b0, 16'd1000);
    push_item(1'b0, 16'd101);   push_item(1'b0, 16'd998);  push_item(1'b0, 16'hFFFF);
    push_item(1'b0, 16'h5555);
    push_item(1'b1, 16'd0);     push_item(1'b1, 16'hAAAA); push_item(1'b1, 16'd0);
    push_item(1'b0, 16'd1000);  push_item(1'b0, 16'd1000); push_item(1'b0, 16'd0);
    push_item(1'b0, 16'd500);   push_item(1'b0, 16'd500);  push_item(1'b0, 16'd500);
    push_item(1'b0, 16'd0);     push_item(1'b0, 16'd500);  push_item(1'b0, 16'd0);
    push_item(1'b1, 16'd0);     push_item(1'b1, 16'd0);    push_item(1'b1, 16'd0);

    // low above high: every pixel falls to none or strong by the low test
    set_frame(65535, 0, 4, 3);
    run_frame(1'b1);
    // width and height of zero are taken as one
    set_frame(0, 65535, 0, 0);
    run_frame(1'b1);
    // single column and a wide two-row frame
    set_frame(1000, 30000, 1, 40);
    run_frame(1'b0);
    set_frame(50, 60, 64, 2);
    run_frame(1'b0);

    phase = 0;
    while (queued < 1500) begin
      if ($urandom_range(0, 3) == 0) w = $urandom_range(9, 32);
      else w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      if ($urandom_range(0, 3) == 0) begin
        lo = $urandom_range(0, 65535);
        hi = $urandom_range(0, 65535);
      end else begin
        lo = $urandom_range(0, 60000);
        hi = lo + $urandom_range(0, 5000);
      end
      if (phase == 0) begin
        w = 48;
        h = 6;
      end
      set_frame(lo, hi, w, h);
      if (phase == 0) long_hold = 1'b1;
      if (queued > 1250) quiet = 1'b1;
      repeat ($urandom_range(1, 2)) begin
        run_frame($urandom_range(0, 3) != 0);
      end
      phase++;
    end

    wait_idle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* double_threshold_hysteresis_core.f */
design/dth_pkg.sv
design/dth_ram.sv
design/dth_queue.sv
design/dth_front.sv
design/dth_back.sv
design/double_threshold_hysteresis_core.sv
sim/tb_double_threshold_hysteresis_core.sv
